// ===== src/repeating_decimal_expander_assert.svh =====
// Assertion macros used by the checker file of the decimal expander.
// Needs clk and rst in scope at the point of use.
`ifndef REPEATING_DECIMAL_EXPANDER_ASSERT_SVH
`define REPEATING_DECIMAL_EXPANDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RDE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RDE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rde_pkg.sv =====
// Shared types and constants of the repeating decimal expander.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rde_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int DATA_W     = 32;
  localparam int XW         = DATA_W + 3;   // remainder times ten
  localparam int CNT_W      = $clog2(DATA_W);
  localparam int DIGIT_W    = 4;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] numerator;
    logic signed [DATA_W-1:0] denominator;
  } rde_in_t;

  typedef struct packed {
    logic               status;
    logic               negative;
    logic [DATA_W-1:0]  integer_part;
    logic               has_digit;
    logic [DIGIT_W-1:0] digit;
    logic               in_cycle;
    logic               last;
  } rde_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_SCAN,
    ST_HEAD,
    ST_ERR,
    ST_EMIT_RD,
    ST_EMIT_WR
  } rde_state_t;

endpackage

`default_nettype wire

// ===== src/rde_div.sv =====
// Restoring divider, one quotient bit per cycle, for the decimal expander.
// Depends on rde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rde_div
  import rde_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quotient,
  output logic [DATA_W-1:0]      remainder
);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // rem < dvs <= 2**(DATA_W-1), so the shifted value fits DATA_W+1 bits
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// ===== src/repeating_decimal_expander.sv =====
// Repeating decimal expander. One item at a time: an accepted beat is
// divided in rde_div, then each fraction digit takes a short division
// plus a scan of the remainder memory at one entry per cycle, and each
// result beat is read from the digit memory before it leaves. A fraction
// has at most 31 digits. A zero denominator gives one error beat. The next
// item is taken as soon as the last result sits in the output register.
// Memories are not cleared after reset.
// Depends on rde_pkg and rde_div.
`timescale 1ns / 1ps
`default_nettype none

module repeating_decimal_expander
  import rde_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rde_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rde_out_t      out_data
);

  rde_state_t state, state_next;

  logic              sign_flag, sign_flag_next;
  logic [DATA_W-1:0] ipart, ipart_next;
  logic [DATA_W-1:0] den, den_next;
  logic [DATA_W-1:0] rem, rem_next;
  logic [XW-1:0]     x, x_next;
  logic [1:0]        dstep, dstep_next;
  logic [DIGIT_W-1:0] qdig, qdig_next;
  logic [IDX_W-1:0]  k, k_next;
  logic [IDX_W-1:0]  cycle_start, cycle_start_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic [IDX_W-1:0]  emit_idx, emit_idx_next;
  logic              out_valid_next;
  rde_out_t          out_data_next;

  // remainder memory
  logic [DATA_W-1:0] tbl_mem [MAX_DIGITS];
  logic              tbl_we, tbl_re;
  logic [IDX_W-1:0]  tbl_wa, tbl_ra;
  logic [DATA_W-1:0] tbl_wd, tbl_rdata;

  // digit memory
  logic [DIGIT_W-1:0] dig_mem [MAX_DIGITS];
  logic               dig_we, dig_re;
  logic [IDX_W-1:0]   dig_wa, dig_ra;
  logic [DIGIT_W-1:0] dig_wd, dig_rdata;

  logic              div_start, div_done;
  logic [DATA_W-1:0] div_q, div_r;

  logic              n_neg, d_neg;
  logic [DATA_W-1:0] n_mag, d_mag;
  logic [XW-1:0]     dshift;
  logic              ge;
  logic [XW-1:0]     x_sub;
  logic              slot_free;

  function automatic logic [XW-1:0] times_ten(input logic [DATA_W-1:0] v);
    return ({{(XW-DATA_W){1'b0}}, v} << 3) + ({{(XW-DATA_W){1'b0}}, v} << 1);
  endfunction

  assign n_neg = in_data.numerator[DATA_W-1];
  assign d_neg = in_data.denominator[DATA_W-1];
  assign n_mag = n_neg ? (DATA_W'(0) - $unsigned(in_data.numerator))
                       : $unsigned(in_data.numerator);
  assign d_mag = d_neg ? (DATA_W'(0) - $unsigned(in_data.denominator))
                       : $unsigned(in_data.denominator);

  assign dshift = {{(XW-DATA_W){1'b0}}, den} << dstep;
  assign ge     = (x >= dshift);
  assign x_sub  = x - dshift;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  rde_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (n_mag),
    .divisor   (d_mag),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    state_next       = state;
    sign_flag_next   = sign_flag;
    ipart_next       = ipart;
    den_next         = den;
    rem_next         = rem;
    x_next           = x;
    dstep_next       = dstep;
    qdig_next        = qdig;
    k_next           = k;
    cycle_start_next = cycle_start;
    scan_idx_next    = scan_idx;
    pend_next        = pend;
    pend_idx_next    = pend_idx;
    emit_idx_next    = emit_idx;
    out_valid_next   = out_valid && !out_ready;
    out_data_next    = out_data;
    tbl_we    = 1'b0;
    tbl_wa    = k;
    tbl_wd    = rem;
    tbl_re    = 1'b0;
    tbl_ra    = scan_idx;
    dig_we    = 1'b0;
    dig_wa    = k;
    dig_wd    = {qdig[DIGIT_W-2:0], ge};
    dig_re    = 1'b0;
    dig_ra    = emit_idx;
    div_start = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (d_mag == '0) begin
            state_next = ST_ERR;
          end else begin
            sign_flag_next = (n_mag != '0) && (n_neg != d_neg);
            den_next       = d_mag;
            div_start      = 1'b1;
            state_next     = ST_DIV;
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{status: STATUS_DIV_ZERO, negative: 1'b0,
                             integer_part: '0, has_digit: 1'b0, digit: '0,
                             in_cycle: 1'b0, last: 1'b1};
          state_next     = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ipart_next = div_q;
          rem_next   = div_r;
          tbl_we     = 1'b1;
          tbl_wa     = '0;
          tbl_wd     = div_r;
          if (div_r == '0) begin
            k_next           = '0;
            cycle_start_next = '0;
            state_next       = ST_HEAD;
          end else begin
            k_next     = IDX_W'(1);
            x_next     = times_ten(div_r);
            dstep_next = 2'd3;
            qdig_next  = '0;
            state_next = ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        // quotient of x/den is below ten: four restoring steps
        x_next    = ge ? x_sub : x;
        qdig_next = {qdig[DIGIT_W-2:0], ge};
        if (dstep == 2'd0) begin
          rem_next      = ge ? x_sub[DATA_W-1:0] : x[DATA_W-1:0];
          dig_we        = 1'b1;
          scan_idx_next = '0;
          pend_next     = 1'b0;
          state_next    = ST_SCAN;
        end else begin
          dstep_next = dstep - 2'd1;
        end
      end
      ST_SCAN: begin
        // the read of each entry 0..k-1 is registered and compared in the cycle after it is issued
        if (pend && tbl_rdata == rem) begin
          cycle_start_next = pend_idx;
          pend_next        = 1'b0;
          state_next       = ST_HEAD;
        end else if (scan_idx != k) begin
          tbl_re        = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan_idx;
          scan_idx_next = scan_idx + 1'b1;
        end else if (!pend) begin
          tbl_we = 1'b1;
          if (rem == '0 || k == IDX_W'(MAX_DIGITS - 1)) begin
            cycle_start_next = k;
            state_next       = ST_HEAD;
          end else begin
            k_next     = k + 1'b1;
            x_next     = times_ten(rem);
            dstep_next = 2'd3;
            qdig_next  = '0;
            state_next = ST_DIGIT;
          end
        end else begin
          pend_next = 1'b0;
        end
      end
      ST_HEAD: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{status: STATUS_OK, negative: sign_flag,
                             integer_part: ipart, has_digit: 1'b0, digit: '0,
                             in_cycle: 1'b0, last: (k == '0)};
          if (k == '0) begin
            state_next = ST_IDLE;
          end else begin
            emit_idx_next = IDX_W'(1);
            state_next    = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_RD: begin
        dig_re     = 1'b1;
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{status: STATUS_OK, negative: sign_flag,
                             integer_part: '0, has_digit: 1'b1, digit: dig_rdata,
                             in_cycle: (emit_idx > cycle_start),
                             last: (emit_idx == k)};
          if (emit_idx == k) begin
            state_next = ST_IDLE;
          end else begin
            emit_idx_next = emit_idx + 1'b1;
            state_next    = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      pend        <= 1'b0;
      sign_flag   <= 1'b0;
      k           <= '0;
      cycle_start <= '0;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      pend        <= pend_next;
      sign_flag   <= sign_flag_next;
      k           <= k_next;
      cycle_start <= cycle_start_next;
    end
  end

  always_ff @(posedge clk) begin
    ipart    <= ipart_next;
    den      <= den_next;
    rem      <= rem_next;
    x        <= x_next;
    dstep    <= dstep_next;
    qdig     <= qdig_next;
    scan_idx <= scan_idx_next;
    pend_idx <= pend_idx_next;
    emit_idx <= emit_idx_next;
    out_data <= out_data_next;
  end

  // writes and reads of the same entry never share a cycle: the scan only
  // covers entries written before the current digit
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (tbl_re) begin
      tbl_rdata <= tbl_mem[tbl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_mem[dig_wa] <= dig_wd;
    end
    if (dig_re) begin
      dig_rdata <= dig_mem[dig_ra];
    end
  end

endmodule

`default_nettype wire

// ===== src/rde_check.sv =====
// Port-level checks for the repeating decimal expander, bound to the top.
// Depends on rde_pkg and repeating_decimal_expander_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "repeating_decimal_expander_assert.svh"

module rde_check
  import rde_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire rde_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire rde_out_t out_data
);

  // a stalled output beat holds
  `RDE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")

  // one item in flight: never ready right after taking a beat
  `RDE_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while busy")

  `RDE_ASSERT_IMP(a_digit_shape, out_valid && out_data.has_digit, out_data.digit <= 4'd9 && out_data.status == STATUS_OK && out_data.integer_part == '0, "bad digit beat")

  `RDE_ASSERT_IMP(a_err_shape, out_valid && out_data.status == STATUS_DIV_ZERO, out_data.last && !out_data.has_digit && !out_data.negative, "bad error beat")

  `RDE_ASSERT_IMP(a_cycle_digit, out_valid && out_data.in_cycle, out_data.has_digit, "cycle flag without digit")

endmodule

bind repeating_decimal_expander rde_check u_rde_check (.*);

`default_nettype wire
